@@ hw/rtl/sra_pkg.sv @@
// Package for the skyline rectangle allocator: microcode types, step labels and program table.
package sra_pkg;

  // Datapath operation selected by one control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INIT_SEARCH,
    OP_MID,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_BS_UPD,
    OP_SET_T_LO,
    OP_DECIDE,
    OP_WRITE,
    OP_SET_OK,
    OP_SET_FAIL,
    OP_COL_ZERO,
    OP_CLEAR,
    OP_SET_CLR,
    OP_EMIT
  } op_t;

  // Jump condition of one control word; when it holds, the step counter loads the target.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_CLEAR,
    C_BAD_ARGS,
    C_LO_GE_HI,
    C_COL_MORE,
    C_NO_FIT,
    C_WR_MORE,
    C_BOOT,
    C_OUT_BUSY
  } cond_t;

  typedef logic [4:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Step labels.
  localparam pc_t P_IDLE     = 5'd0;
  localparam pc_t P_DISPATCH = 5'd1;
  localparam pc_t P_ARGS     = 5'd2;
  localparam pc_t P_BS       = 5'd3;
  localparam pc_t P_BS_INIT  = 5'd4;
  localparam pc_t P_BS_SCAN  = 5'd5;
  localparam pc_t P_BS_UPD   = 5'd6;
  localparam pc_t P_FINAL    = 5'd7;
  localparam pc_t P_FN_INIT  = 5'd8;
  localparam pc_t P_FN_SCAN  = 5'd9;
  localparam pc_t P_DECIDE   = 5'd10;
  localparam pc_t P_WRITE    = 5'd11;
  localparam pc_t P_OK       = 5'd12;
  localparam pc_t P_FAIL     = 5'd13;
  localparam pc_t P_EMIT     = 5'd14;
  localparam pc_t P_BACK     = 5'd15;
  localparam pc_t P_CLR      = 5'd16;
  localparam pc_t P_CLR_LOOP = 5'd17;
  localparam pc_t P_CLR_DONE = 5'd18;
  localparam pc_t P_CLR_OUT  = 5'd19;

  // Microprogram: binary search on the window height bound, final scan and write pass, or a clear.
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t uw;
    unique case (pc)
      P_IDLE:     uw = '{OP_ACCEPT,      C_NO_INPUT, P_IDLE};
      P_DISPATCH: uw = '{OP_NOP,         C_IS_CLEAR, P_CLR};
      P_ARGS:     uw = '{OP_INIT_SEARCH, C_BAD_ARGS, P_FAIL};
      P_BS:       uw = '{OP_MID,         C_LO_GE_HI, P_FINAL};
      P_BS_INIT:  uw = '{OP_SCAN_INIT,   C_NEVER,    P_IDLE};
      P_BS_SCAN:  uw = '{OP_SCAN,        C_COL_MORE, P_BS_SCAN};
      P_BS_UPD:   uw = '{OP_BS_UPD,      C_ALWAYS,   P_BS};
      P_FINAL:    uw = '{OP_SET_T_LO,    C_NEVER,    P_IDLE};
      P_FN_INIT:  uw = '{OP_SCAN_INIT,   C_NEVER,    P_IDLE};
      P_FN_SCAN:  uw = '{OP_SCAN,        C_COL_MORE, P_FN_SCAN};
      P_DECIDE:   uw = '{OP_DECIDE,      C_NO_FIT,   P_FAIL};
      P_WRITE:    uw = '{OP_WRITE,       C_WR_MORE,  P_WRITE};
      P_OK:       uw = '{OP_SET_OK,      C_ALWAYS,   P_EMIT};
      P_FAIL:     uw = '{OP_SET_FAIL,    C_NEVER,    P_IDLE};
      P_EMIT:     uw = '{OP_EMIT,        C_OUT_BUSY, P_EMIT};
      P_BACK:     uw = '{OP_NOP,         C_ALWAYS,   P_IDLE};
      P_CLR:      uw = '{OP_COL_ZERO,    C_NEVER,    P_IDLE};
      P_CLR_LOOP: uw = '{OP_CLEAR,       C_COL_MORE, P_CLR_LOOP};
      P_CLR_DONE: uw = '{OP_SET_CLR,     C_BOOT,     P_IDLE};
      P_CLR_OUT:  uw = '{OP_NOP,         C_ALWAYS,   P_EMIT};
      default:    uw = '{OP_NOP,         C_ALWAYS,   P_IDLE};
    endcase
    return uw;
  endfunction

endpackage

@@ hw/rtl/sra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/skyline_rect_allocator_top.sv @@
// Skyline rectangle allocator: microcoded sequencer over a column fill height RAM.
// An allocate runs a binary search on the window height bound, each probe a full column scan
// over the single RAM read port, then a final scan and a write pass of rect_width columns; a
// failed fit skips the writes and a zero or too wide size goes straight to the fail step. A
// clear zeroes every column. One item is in flight at a time; after the result loads, the
// P_BACK step returns to idle, where the next word is taken. After reset a clearing pass
// zeroes the columns; no word is taken.
module skyline_rect_allocator_top #(
  parameter int SHEET_WIDTH  = 128,
  parameter int SHEET_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rect_width [7:0], rect_height [15:8]
  input  logic        in_tuser,   // cmd [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pos_x [6:0], pos_y [13:7], peak_height [21:14], zero pad
  output logic        out_tuser   // placed [0]
);

  localparam int CW = $clog2(SHEET_WIDTH);
  localparam int VW = $clog2(SHEET_HEIGHT + 1);
  localparam int RW = $clog2(SHEET_WIDTH + 1);

  sra_pkg::pc_t    pc_r, pc_nxt;
  sra_pkg::uword_t uw;
  logic            cond_hit;

  logic            boot_r, boot_nxt;
  logic            cmd_r, cmd_nxt;
  logic [7:0]      w_r, w_nxt;
  logic [7:0]      h_r, h_nxt;
  logic [VW-1:0]   lo_r, lo_nxt;
  logic [VW-1:0]   hi_r, hi_nxt;
  logic [VW-1:0]   t_r, t_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   run_r, run_nxt;
  logic            hit_r, hit_nxt;
  logic [CW-1:0]   hitx_r, hitx_nxt;
  logic [CW-1:0]   wcnt_r, wcnt_nxt;
  logic            res_placed_r, res_placed_nxt;
  logic [CW-1:0]   res_x_r, res_x_nxt;
  logic [VW-1:0]   res_y_r, res_y_nxt;
  logic [VW-1:0]   peak_r, peak_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [23:0]     out_tdata_r, out_tdata_nxt;
  logic            out_tuser_r, out_tuser_nxt;

  logic            ram_we;
  logic [CW-1:0]   ram_waddr;
  logic [VW-1:0]   ram_wdata;
  logic [CW-1:0]   ram_raddr;
  logic [VW-1:0]   ram_rdata;

  logic [VW-1:0]   fill_new;
  logic [VW-1:0]   mid;
  logic            out_busy;
  logic [RW-1:0]   run_step;

  // Column fill height store.
  sra_ram #(
    .WIDTH (VW),
    .DEPTH (SHEET_WIDTH)
  ) u_fill_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign uw        = sra_pkg::ucode_rom(pc_r);
  assign fill_new  = VW'(32'(t_r) + 32'(h_r));
  assign mid       = VW'((32'(lo_r) + 32'(hi_r)) >> 1);
  assign out_busy  = out_valid_r && !out_tready;
  assign run_step  = (ram_rdata <= t_r) ? RW'(32'(run_r) + 32'd1) : '0;

  assign in_tready  = (pc_r == sra_pkg::P_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Jump condition of the current control word.
  always_comb begin
    unique case (uw.cond)
      sra_pkg::C_NEVER:    cond_hit = 1'b0;
      sra_pkg::C_ALWAYS:   cond_hit = 1'b1;
      sra_pkg::C_NO_INPUT: cond_hit = !in_tvalid;
      sra_pkg::C_IS_CLEAR: cond_hit = cmd_r;
      sra_pkg::C_BAD_ARGS: cond_hit = (w_r == 8'd0) || (h_r == 8'd0) ||
                                      (32'(w_r) > 32'(SHEET_WIDTH));
      sra_pkg::C_LO_GE_HI: cond_hit = (lo_r >= hi_r);
      sra_pkg::C_COL_MORE: cond_hit = (col_r != CW'(SHEET_WIDTH - 1));
      sra_pkg::C_NO_FIT:   cond_hit = !hit_r ||
                                      (32'(t_r) + 32'(h_r) > 32'(SHEET_HEIGHT));
      sra_pkg::C_WR_MORE:  cond_hit = (32'(wcnt_r) + 32'd1 != 32'(w_r));
      sra_pkg::C_BOOT:     cond_hit = boot_r;
      sra_pkg::C_OUT_BUSY: cond_hit = out_busy;
      default:             cond_hit = 1'b0;
    endcase
  end

  // Datapath driven by the control word, and the step counter.
  always_comb begin
    boot_nxt       = boot_r;
    cmd_nxt        = cmd_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    t_nxt          = t_r;
    col_nxt        = col_r;
    run_nxt        = run_r;
    hit_nxt        = hit_r;
    hitx_nxt       = hitx_r;
    wcnt_nxt       = wcnt_r;
    res_placed_nxt = res_placed_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    peak_nxt       = peak_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    ram_we         = 1'b0;
    ram_waddr      = col_r;
    ram_wdata      = '0;
    ram_raddr      = col_r;

    // A waiting word leaves when the consumer takes it.
    out_valid_nxt  = out_valid_r && !out_tready;

    unique case (uw.op)
      sra_pkg::OP_NOP: begin
      end
      sra_pkg::OP_ACCEPT: begin
        if (in_tvalid) begin
          cmd_nxt = in_tuser;
          w_nxt   = in_tdata[7:0];
          h_nxt   = in_tdata[15:8];
        end
      end
      sra_pkg::OP_INIT_SEARCH: begin
        lo_nxt = '0;
        hi_nxt = VW'(SHEET_HEIGHT - 1);
      end
      sra_pkg::OP_MID: begin
        t_nxt = mid;
      end
      sra_pkg::OP_SCAN_INIT: begin
        col_nxt   = '0;
        run_nxt   = '0;
        hit_nxt   = 1'b0;
        ram_raddr = '0;
      end
      sra_pkg::OP_SCAN: begin
        // Count the run of columns at or below the bound; the first full run is the window.
        run_nxt   = run_step;
        ram_raddr = CW'(32'(col_r) + 32'd1);
        col_nxt   = CW'(32'(col_r) + 32'd1);
        if (!hit_r && (32'(run_step) == 32'(w_r))) begin
          hit_nxt  = 1'b1;
          hitx_nxt = CW'(32'(col_r) + 32'd1 - 32'(w_r));
        end
      end
      sra_pkg::OP_BS_UPD: begin
        if (hit_r) begin
          hi_nxt = t_r;
        end else begin
          lo_nxt = VW'(32'(t_r) + 32'd1);
        end
      end
      sra_pkg::OP_SET_T_LO: begin
        t_nxt = lo_r;
      end
      sra_pkg::OP_DECIDE: begin
        col_nxt  = hitx_r;
        wcnt_nxt = '0;
      end
      sra_pkg::OP_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = fill_new;
        col_nxt   = CW'(32'(col_r) + 32'd1);
        wcnt_nxt  = CW'(32'(wcnt_r) + 32'd1);
      end
      sra_pkg::OP_SET_OK: begin
        res_placed_nxt = 1'b1;
        res_x_nxt      = hitx_r;
        res_y_nxt      = t_r;
        if (fill_new > peak_r) begin
          peak_nxt = fill_new;
        end
      end
      sra_pkg::OP_SET_FAIL: begin
        res_placed_nxt = 1'b0;
        res_x_nxt      = '0;
        res_y_nxt      = '0;
      end
      sra_pkg::OP_COL_ZERO: begin
        col_nxt = '0;
      end
      sra_pkg::OP_CLEAR: begin
        ram_we  = 1'b1;
        col_nxt = CW'(32'(col_r) + 32'd1);
      end
      sra_pkg::OP_SET_CLR: begin
        res_placed_nxt = 1'b1;
        res_x_nxt      = '0;
        res_y_nxt      = '0;
        peak_nxt       = '0;
        boot_nxt       = 1'b0;
      end
      sra_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_tuser_nxt = res_placed_r;
          out_tdata_nxt = {2'b00, 8'(peak_r), 7'(res_y_r), 7'(res_x_r)};
        end
      end
      default: begin
      end
    endcase

    // Step counter: jump on a true condition, otherwise go to the next step.
    if (cond_hit) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = sra_pkg::pc_t'(pc_r + 5'd1);
    end
  end

  // Control state with reset; payload registers without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= sra_pkg::P_CLR;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
    end else begin
      pc_r        <= pc_nxt;
      boot_r      <= boot_nxt;
      out_valid_r <= out_valid_nxt;
      peak_r      <= peak_nxt;
    end
    cmd_r        <= cmd_nxt;
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    t_r          <= t_nxt;
    col_r        <= col_nxt;
    run_r        <= run_nxt;
    hit_r        <= hit_nxt;
    hitx_r       <= hitx_nxt;
    wcnt_r       <= wcnt_nxt;
    res_placed_r <= res_placed_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

endmodule
